/* rtl/core/ebrd_pkg.sv */
// Package for the encoder/button report decoder: word layouts, event codes,
// register indexes and reset values. No dependencies.
package ebrd_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int LEN_W        = 7;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int MAX_RESULTS = 3;

    // event codes
    localparam logic [2:0] EV_ENCODER  = 3'd0;
    localparam logic [2:0] EV_PRESSED  = 3'd1;
    localparam logic [2:0] EV_RELEASED = 3'd2;
    localparam logic [2:0] EV_TAPPED   = 3'd3;
    localparam logic [2:0] EV_HELD     = 3'd4;

    // report byte values
    localparam logic [7:0] TYPE_VERSION = 8'h02;
    localparam logic [7:0] DIR_FWD      = 8'h01;
    localparam logic [7:0] DIR_BACK     = 8'h02;
    localparam logic [2:0] SPEED_MIN    = 3'd1;
    localparam logic [2:0] SPEED_MAX    = 3'd4;

    // longest report lengths that still lack a byte
    localparam logic [LEN_W-1:0] LEN_HAS_SPEED = 7'd1;
    localparam logic [LEN_W-1:0] LEN_HAS_DIR   = 7'd3;
    localparam logic [LEN_W-1:0] LEN_HAS_CTL   = 7'd5;

    // input kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // button numbers
    localparam logic [1:0] BTN_OFF    = 2'd0;
    localparam logic [1:0] BTN_FIRST  = 2'd1;
    localparam logic [1:0] BTN_SECOND = 2'd2;
    localparam logic [1:0] BTN_TX     = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CODE_NONE   = 3'd0;
    localparam logic [2:0] REG_CODE_FIRST  = 3'd1;
    localparam logic [2:0] REG_CODE_SECOND = 3'd2;
    localparam logic [2:0] REG_CODE_TX     = 3'd3;
    localparam logic [2:0] REG_HOLD_TICKS  = 3'd4;

    localparam logic [7:0]  RST_CODE_NONE   = 8'd0;
    localparam logic [7:0]  RST_CODE_FIRST  = 8'd1;
    localparam logic [7:0]  RST_CODE_SECOND = 8'd2;
    localparam logic [7:0]  RST_CODE_TX     = 8'd4;
    localparam logic [15:0] RST_HOLD_TICKS  = 16'd500;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [1:0]        button;
        logic signed [3:0] ticks;
    } result_t;

    // all results of one input word, in emission order from index 0
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } job_t;

endpackage

/* rtl/core/ebrd_front.sv */
// Front end: config registers, report decode and button tracking state.
// Builds one job per input word. Depends on ebrd_pkg.
module ebrd_front import ebrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_acc,
    input  logic        in_kind,
    input  logic [39:0] in_data,
    output logic        job_push,
    output job_t        job
);

    logic [7:0]  code_none_reg, code_first_reg, code_second_reg, code_tx_reg;
    logic [15:0] hold_ticks_reg;

    logic [1:0]  held_button_reg, held_button_next;
    logic        hold_sent_reg, hold_sent_next;
    logic        running_reg, running_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [LEN_W-1:0] len;
    logic [7:0]       type_b, speed_b, dir_b, ctl_b;

    assign len    = in_data[6:0];
    assign type_b = in_data[14:7];
    assign speed_b = in_data[22:15];
    assign dir_b  = in_data[30:23];
    assign ctl_b  = in_data[38:31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_none_reg   <= RST_CODE_NONE;
            code_first_reg  <= RST_CODE_FIRST;
            code_second_reg <= RST_CODE_SECOND;
            code_tx_reg     <= RST_CODE_TX;
            hold_ticks_reg  <= RST_HOLD_TICKS;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_CODE_NONE:   code_none_reg   <= cfg_data[7:0];
                REG_CODE_FIRST:  code_first_reg  <= cfg_data[7:0];
                REG_CODE_SECOND: code_second_reg <= cfg_data[7:0];
                REG_CODE_TX:     code_tx_reg     <= cfg_data[7:0];
                REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [1:0]  n;
        logic [7:0]  ctl_eff, dir_eff, speed_eff;
        logic [2:0]  speed_c;
        logic [1:0]  down;
        logic [15:0] el_t;

        n                = 2'd0;
        job              = '0;
        held_button_next = held_button_reg;
        hold_sent_next   = hold_sent_reg;
        running_next     = running_reg;
        elapsed_next     = elapsed_reg;
        ctl_eff          = (len > LEN_HAS_CTL) ? ctl_b : code_none_reg;
        dir_eff          = (len > LEN_HAS_DIR) ? dir_b : 8'd0;
        speed_eff        = (len > LEN_HAS_SPEED) ? speed_b : {5'd0, SPEED_MIN};
        down             = BTN_OFF;
        el_t             = elapsed_reg;

        if (speed_eff < {5'd0, SPEED_MIN}) begin
            speed_c = SPEED_MIN;
        end else if (speed_eff > {5'd0, SPEED_MAX}) begin
            speed_c = SPEED_MAX;
        end else begin
            speed_c = speed_eff[2:0];
        end

        if (in_kind == KIND_TICK) begin
            if (running_reg && (elapsed_reg < hold_ticks_reg)) begin
                el_t = elapsed_reg + 16'd1;
            end
            elapsed_next = el_t;
            if ((held_button_reg != BTN_OFF) && !hold_sent_reg && running_reg
                    && (el_t >= hold_ticks_reg)) begin
                job.res[n] = '{EV_HELD, held_button_reg, 4'sd0};
                n = n + 2'd1;
                hold_sent_next = 1'b1;
            end
        end else if ((len != '0) && (type_b != TYPE_VERSION)) begin
            // code_none wins over the button codes
            priority if (ctl_eff == code_none_reg) begin
                if (dir_eff == DIR_FWD) begin
                    job.res[n] = '{EV_ENCODER, BTN_OFF, signed'({1'b0, speed_c})};
                    n = n + 2'd1;
                end else if (dir_eff == DIR_BACK) begin
                    job.res[n] = '{EV_ENCODER, BTN_OFF,
                                   signed'(4'd0 - {1'b0, speed_c})};
                    n = n + 2'd1;
                end
                down = BTN_OFF;
            end else if (ctl_eff == code_first_reg) begin
                down = BTN_FIRST;
            end else if (ctl_eff == code_second_reg) begin
                down = BTN_SECOND;
            end else if (ctl_eff == code_tx_reg) begin
                down = BTN_TX;
            end else begin
                down = BTN_OFF;
            end

            if (down != held_button_reg) begin
                if (held_button_reg != BTN_OFF) begin
                    job.res[n] = '{EV_RELEASED, held_button_reg, 4'sd0};
                    n = n + 2'd1;
                    if (!hold_sent_reg) begin
                        job.res[n] = '{EV_TAPPED, held_button_reg, 4'sd0};
                        n = n + 2'd1;
                    end
                end
                held_button_next = down;
                hold_sent_next   = 1'b0;
                if (down != BTN_OFF) begin
                    running_next = 1'b1;
                    elapsed_next = 16'd0;
                    job.res[n]   = '{EV_PRESSED, down, 4'sd0};
                    n = n + 2'd1;
                end else begin
                    running_next = 1'b0;
                end
            end else if ((down != BTN_OFF) && !hold_sent_reg && running_reg
                         && (elapsed_reg >= hold_ticks_reg)) begin
                job.res[n] = '{EV_HELD, held_button_reg, 4'sd0};
                n = n + 2'd1;
                hold_sent_next = 1'b1;
            end
        end
        job.count = n;
    end

    assign job_push = in_acc && (job.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_button_reg <= BTN_OFF;
            hold_sent_reg   <= 1'b0;
            running_reg     <= 1'b0;
            elapsed_reg     <= 16'd0;
        end else if (in_acc) begin
            held_button_reg <= held_button_next;
            hold_sent_reg   <= hold_sent_next;
            running_reg     <= running_next;
            elapsed_reg     <= elapsed_next;
        end
    end

endmodule

/* rtl/core/ebrd_queue.sv */
// Short job queue between front and back, QDEPTH entries in flops.
// Depends on ebrd_pkg.
module ebrd_queue import ebrd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/ebrd_back.sv */
// Back end: walks each job one result per cycle into the output register, while that register is free or taken.
// Depends on ebrd_pkg.
module ebrd_back import ebrd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  job_t    head_job,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic    out_last
);

    job_t       job_reg;
    logic [1:0] pos_reg;
    logic       have_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       out_last_reg;

    job_t       src;
    logic [1:0] pos;
    logic       slot_free, take, at_end;

    assign src       = have_reg ? job_reg : head_job;
    assign pos       = have_reg ? pos_reg : 2'd0;
    assign slot_free = !out_valid_reg || out_ready;
    assign take      = slot_free && (have_reg || head_valid);
    assign at_end    = (pos == src.count - 2'd1);
    assign pop       = take && !have_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end else begin
            if (take) begin
                out_valid_reg <= 1'b1;
                have_reg      <= !at_end;
                pos_reg       <= pos + 2'd1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
        if (take) begin
            out_res_reg  <= src.res[pos];
            out_last_reg <= at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/core/encoder_button_report_decoder.sv */
// Top level of the encoder/button report decoder.
// Instantiates ebrd_front, ebrd_queue and ebrd_back; depends on ebrd_pkg.
//
// Usage
//  - s_ channel: one word per received report or per elapsed time tick.
//    s_tuser selects the kind (0 report, 1 tick); s_tdata carries the
//    report length and the type, speed, direction and control bytes.
//  - m_ channel: event words. m_tuser is the event code, m_tdata the button
//    and signed tick count, m_tlast marks the final event of an input word.
//    An input word gives zero to three events.
//  - cfg_ channel: register writes, always ready. Write only while idle.
//  - Path: a taken word's job is written to the job queue, then its first event
//    to the output register; decode and button tracking finish in the accepting cycle.
//  - Throughput: a word is taken every cycle while the four-entry job queue
//    has room; the output side sends one event per cycle while m_tready is high,
//    so a word with several events holds the output until its last is sent.
//  - Receiver stall: the output register holds its word; the queue fills,
//    and then s_tready drops until an entry drains.
//  - Reset (aresetn low, synchronous): queue emptied, button state cleared,
//    registers back to their defaults.
module encoder_button_report_decoder import ebrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // report_len[6:0], type_byte[14:7], speed_byte[22:15],
                                   // direction_byte[30:23], control_byte[38:31], 0[39]
    input  logic        s_tuser,   // kind[0]
    // event words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // button[1:0], ticks[5:2], 0[7:6]
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic        m_tlast,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    q_full, q_head_valid, q_pop, job_push, in_acc;
    job_t    job_new, q_head;
    result_t out_res;

    assign s_tready  = !q_full;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // front: decode, button tracking, job build
    ebrd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_acc    (in_acc),
        .in_kind   (s_tuser),
        .in_data   (s_tdata),
        .job_push  (job_push),
        .job       (job_new)
    );

    // jobs with no events are never queued
    ebrd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (job_new),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head)
    );

    // back: one event per cycle into the output register while the receiver takes them
    ebrd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_res.event_res;
    assign m_tdata = {2'b00, out_res.ticks, out_res.button};

endmodule
